@@ design/elfa_pkg.sv @@
// Package for the earliest free lane assigner.
// Holds the finish time width, the scan candidate type and the sequencer states.
// No dependencies.
package elfa_pkg;

    localparam int TIME_W = 32;
    localparam int SVC_W  = 16;
    localparam int LANE_W = 7;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic              vld;
        logic [TIME_W-1:0] t;
    } t_cand;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

@@ design/elfa_if.sv @@
// Handshake interfaces for the job and result channels.
// Depends on elfa_pkg for the field widths.
interface elfa_job_if import elfa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SVC_W-1:0]  service_time;
    logic              first_job;

    modport source (output valid, output service_time, output first_job, input ready);
    modport sink   (input valid, input service_time, input first_job, output ready);
endinterface

interface elfa_res_if import elfa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [LANE_W-1:0] assigned_lane;
    logic [LANE_W-1:0] next_free_lane;

    modport source (output valid, output assigned_lane, output next_free_lane, input ready);
    modport sink   (input valid, input assigned_lane, input next_free_lane, output ready);
endinterface

@@ design/elfa_cell.sv @@
// One lane cell: holds the lane finish time and folds it into the
// best and second-best candidates handed down the chain. Depends on elfa_pkg.
module elfa_cell import elfa_pkg::*; #(
    parameter int LANE  = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_clr,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  logic [TIME_W-1:0] i_wr_time,
    input  t_cand             i_best,
    input  logic [IDX_W-1:0]  i_best_idx,
    input  t_cand             i_sec,
    input  logic [IDX_W-1:0]  i_sec_idx,
    output t_cand             o_best,
    output logic [IDX_W-1:0]  o_best_idx,
    output t_cand             o_sec,
    output logic [IDX_W-1:0]  o_sec_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(LANE);

    logic [TIME_W-1:0] r_time;
    t_cand             r_best;
    t_cand             r_sec;
    logic [IDX_W-1:0]  r_best_idx;
    logic [IDX_W-1:0]  r_sec_idx;

    t_cand             n_best;
    t_cand             n_sec;
    logic [IDX_W-1:0]  n_best_idx;
    logic [IDX_W-1:0]  n_sec_idx;
    logic              active;

    assign active = (i_count > CNT_W'(LANE));

    always_comb begin
        n_best     = i_best;
        n_best_idx = i_best_idx;
        n_sec      = i_sec;
        n_sec_idx  = i_sec_idx;
        if (active) begin
            if (!i_best.vld || (r_time < i_best.t)) begin
                n_best     = '{vld: 1'b1, t: r_time};
                n_best_idx = MY_IDX;
                n_sec      = i_best;
                n_sec_idx  = i_best_idx;
            end else if (!i_sec.vld || (r_time < i_sec.t)) begin
                n_sec      = '{vld: 1'b1, t: r_time};
                n_sec_idx  = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_clr) begin
            r_time <= '0;
        end else if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_time <= i_wr_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_sec      <= n_sec;
        r_sec_idx  <= n_sec_idx;
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;
    assign o_sec      = r_sec;
    assign o_sec_idx  = r_sec_idx;

endmodule

@@ design/earliest_free_lane_assigner_top.sv @@
// Earliest free lane assigner: a chain of MAX_LANES lane cells, one cell per lane.
// A job beat starts the scan down the cell chain, one cell per cycle; the result register
// loads once the output is free. A new job is taken only in idle, after that result load.
// A new job beat is taken while a finished result still waits on the output.
// Reset (synchronous, active low): all finish times zero, lane_count 1, no result.
// Depends on elfa_pkg, elfa_if and elfa_cell.
module earliest_free_lane_assigner_top import elfa_pkg::*; #(
    parameter int MAX_LANES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LANE_W-1:0] i_cfg_wdata,
    elfa_job_if.sink          i_job,
    elfa_res_if.source        o_res
);

    localparam int IDX_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int CNT_W = $clog2(MAX_LANES + 1);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_LANES - 1);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [SVC_W-1:0]   r_service;
    logic [LANE_W-1:0]  r_lane_count;
    logic               r_out_vld;
    logic [LANE_W-1:0]  r_assigned;
    logic [LANE_W-1:0]  r_next;

    logic [CNT_W-1:0]   eff_count;
    logic               job_fire;
    logic               res_fire;
    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  new_time;
    logic               pick_stays;
    logic [IDX_W-1:0]   next_idx;

    t_cand              w_best     [MAX_LANES+1];
    t_cand              w_sec      [MAX_LANES+1];
    logic [IDX_W-1:0]   w_best_idx [MAX_LANES+1];
    logic [IDX_W-1:0]   w_sec_idx  [MAX_LANES+1];

    // Clamp the lane count into 1..MAX_LANES
    always_comb begin
        if (r_lane_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (int'(r_lane_count) > MAX_LANES) begin
            eff_count = CNT_W'(MAX_LANES);
        end else begin
            eff_count = CNT_W'(r_lane_count);
        end
    end

    assign w_best[0]     = '0;
    assign w_sec[0]      = '0;
    assign w_best_idx[0] = '0;
    assign w_sec_idx[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_LANES; g++) begin : g_cell
            elfa_cell #(
                .LANE  (g),
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_count    (eff_count),
                .i_clr      (job_fire && i_job.first_job),
                .i_wr_en    (res_fire),
                .i_wr_idx   (w_best_idx[MAX_LANES]),
                .i_wr_time  (new_time),
                .i_best     (w_best[g]),
                .i_best_idx (w_best_idx[g]),
                .i_sec      (w_sec[g]),
                .i_sec_idx  (w_sec_idx[g]),
                .o_best     (w_best[g+1]),
                .o_best_idx (w_best_idx[g+1]),
                .o_sec      (w_sec[g+1]),
                .o_sec_idx  (w_sec_idx[g+1])
            );
        end
    endgenerate

    assign job_fire = i_job.valid && i_job.ready;
    assign res_fire = (r_state == ST_DONE) && (!r_out_vld || o_res.ready);

    // Saturating update of the picked lane
    assign sum      = {1'b0, w_best[MAX_LANES].t} + {{(TIME_W + 1 - SVC_W){1'b0}}, r_service};
    assign new_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    assign pick_stays = !w_sec[MAX_LANES].vld
                        || (new_time < w_sec[MAX_LANES].t)
                        || ((new_time == w_sec[MAX_LANES].t)
                            && (w_best_idx[MAX_LANES] < w_sec_idx[MAX_LANES]));
    assign next_idx   = pick_stays ? w_best_idx[MAX_LANES] : w_sec_idx[MAX_LANES];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (job_fire) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == SCAN_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_job.ready = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_lane_count <= LANE_W'(1);
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (job_fire) begin
                r_cnt <= '0;
            end else if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_lane_count <= i_cfg_wdata;
            end
            if (res_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_fire) begin
            r_service <= i_job.service_time;
        end
        if (res_fire) begin
            r_assigned <= LANE_W'({1'b0, w_best_idx[MAX_LANES]} + 1'b1);
            r_next     <= LANE_W'({1'b0, next_idx} + 1'b1);
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.assigned_lane  = r_assigned;
    assign o_res.next_free_lane = r_next;

endmodule

@@ dv/earliest_free_lane_assigner_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for earliest_free_lane_assigner_top: a directed job table, then random phases.
// Results come from the table for typed rows, else are predicted from a shadow copy of the
// lane finish times, and are checked beat by beat. Depends on elfa_pkg, elfa_if and the RTL of the block.
module earliest_free_lane_assigner_top_tb;
    import elfa_pkg::*;

    localparam int          CLK_PERIOD = 10;
    localparam int          NUM_LANES  = 64;
    localparam int          RAND_JOBS  = 1700;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int          DRAIN_CYC  = 80;

    typedef enum logic {
        ROW_CFG,
        ROW_JOB
    } t_row_kind;

    typedef struct packed {
        logic [LANE_W-1:0] assigned;
        logic [LANE_W-1:0] next_free;
    } t_lane_pick;

    typedef struct packed {
        t_row_kind         kind;
        logic [LANE_W-1:0] lanes;
        logic [SVC_W-1:0]  svc;
        logic              first;
        logic              typed;
        logic [LANE_W-1:0] exp_assigned;
        logic [LANE_W-1:0] exp_next;
    } t_job_row;

    localparam int DIR_ROWS = 27;
    localparam t_job_row DIR_TABLE [DIR_ROWS] = '{
        '{ROW_JOB, 7'd0,   16'd5,      1'b0, 1'b1, 7'd1, 7'd1},
        '{ROW_JOB, 7'd0,   16'd0,      1'b0, 1'b1, 7'd1, 7'd1},
        '{ROW_CFG, 7'd0,   16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd65535,  1'b1, 1'b1, 7'd1, 7'd1},
        '{ROW_CFG, 7'd4,   16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd10,     1'b1, 1'b1, 7'd1, 7'd2},
        '{ROW_JOB, 7'd0,   16'd10,     1'b0, 1'b1, 7'd2, 7'd3},
        '{ROW_JOB, 7'd0,   16'd5,      1'b0, 1'b1, 7'd3, 7'd4},
        '{ROW_JOB, 7'd0,   16'd20,     1'b0, 1'b1, 7'd4, 7'd3},
        '{ROW_JOB, 7'd0,   16'd0,      1'b0, 1'b1, 7'd3, 7'd3},
        '{ROW_CFG, 7'd2,   16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd1,      1'b0, 1'b1, 7'd1, 7'd2},
        '{ROW_JOB, 7'd0,   16'd1,      1'b0, 1'b1, 7'd2, 7'd1},
        '{ROW_CFG, 7'd4,   16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd100,    1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_CFG, 7'd64,  16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd65535,  1'b1, 1'b1, 7'd1, 7'd2},
        '{ROW_JOB, 7'd0,   16'd1,      1'b0, 1'b1, 7'd2, 7'd3},
        '{ROW_CFG, 7'd65,  16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd7,      1'b1, 1'b1, 7'd1, 7'd2},
        '{ROW_CFG, 7'd127, 16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd65535,  1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_CFG, 7'd1,   16'd0,      1'b0, 1'b0, 7'd0, 7'd0},
        '{ROW_JOB, 7'd0,   16'd3,      1'b1, 1'b1, 7'd1, 7'd1},
        '{ROW_JOB, 7'd0,   16'h5555,   1'b0, 1'b1, 7'd1, 7'd1},
        '{ROW_JOB, 7'd0,   16'hAAAA,   1'b0, 1'b1, 7'd1, 7'd1}
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [LANE_W-1:0] cfg_wdata = '0;
    logic              job_valid = 1'b0;
    logic [SVC_W-1:0]  job_svc   = '0;
    logic              job_first = 1'b0;
    logic              sink_ready = 1'b0;

    logic [TIME_W-1:0] finish_t [NUM_LANES];
    logic [LANE_W-1:0] lanes_in_use;
    t_lane_pick        pending_picks [$];

    int unsigned jobs_sent   = 0;
    int unsigned mismatches  = 0;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;
    logic [11:0] cyc_q       = '0;

    wire quiet = (cyc_q[11:9] == 3'd0);

    elfa_job_if job_if ();
    elfa_res_if res_if ();

    assign job_if.valid        = job_valid;
    assign job_if.service_time = job_svc;
    assign job_if.first_job    = job_first;
    assign res_if.ready        = sink_ready;

    earliest_free_lane_assigner_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_job       (job_if),
        .o_res       (res_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 10);
        end
        return $urandom_range(20, 90);
    endfunction

    function automatic int unsigned earliest_lane(int unsigned n);
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i < n; i++) begin
            if (finish_t[i] < finish_t[best]) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic t_lane_pick place_job(logic [SVC_W-1:0] svc, logic first);
        int unsigned n;
        int unsigned pick;
        logic [TIME_W:0] sum;
        t_lane_pick res;
        if (lanes_in_use == 0) begin
            n = 1;
        end else if (lanes_in_use > NUM_LANES) begin
            n = NUM_LANES;
        end else begin
            n = 32'(lanes_in_use);
        end
        if (first) begin
            foreach (finish_t[i]) finish_t[i] = '0;
        end
        pick = earliest_lane(n);
        sum = {1'b0, finish_t[pick]} + {{(TIME_W + 1 - SVC_W){1'b0}}, svc};
        finish_t[pick] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        res.assigned  = LANE_W'(pick + 1);
        res.next_free = LANE_W'(earliest_lane(n) + 1);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: lane mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_job(input logic [SVC_W-1:0] svc, input logic first,
                            input logic typed, input t_lane_pick typed_pick);
        int unsigned gap;
        t_lane_pick want;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            job_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_valid <= 1'b1;
        job_svc   <= svc;
        job_first <= first;
        @(posedge clk);
        while (!job_if.ready) @(posedge clk);
        want = place_job(svc, first);
        pending_picks.push_back(typed ? typed_pick : want);
        jobs_sent++;
    endtask

    task automatic set_lane_count(input logic [LANE_W-1:0] val);
        job_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        lanes_in_use = val;
    endtask

    task automatic check_pick(input logic [LANE_W-1:0] assigned, input logic [LANE_W-1:0] nxt);
        t_lane_pick want;
        if (pending_picks.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, lane %0d", assigned));
        end else begin
            want = pending_picks.pop_front();
            if (assigned !== want.assigned) begin
                report_mismatch($sformatf("assigned_lane %0d, want %0d", assigned,
                                          want.assigned));
            end
            if (nxt !== want.next_free) begin
                report_mismatch($sformatf("next_free_lane %0d, want %0d", nxt, want.next_free));
            end
        end
    endtask

    always @(posedge clk) begin
        cyc_q <= cyc_q + 12'd1;
        if (rst_n && res_if.valid && sink_ready) begin
            check_pick(res_if.assigned_lane, res_if.next_free_lane);
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if ((job_valid && job_if.ready) || (res_if.valid && sink_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("earliest_free_lane_assigner_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        int unsigned burst;
        int unsigned base;
        logic [LANE_W-1:0] lanes;
        logic [SVC_W-1:0] svc;

        foreach (finish_t[i]) finish_t[i] = '0;
        lanes_in_use = 7'd1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].kind == ROW_CFG) begin
                set_lane_count(DIR_TABLE[i].lanes);
            end else begin
                send_job(DIR_TABLE[i].svc, DIR_TABLE[i].first, DIR_TABLE[i].typed,
                         t_lane_pick'{DIR_TABLE[i].exp_assigned, DIR_TABLE[i].exp_next});
            end
        end

        base = jobs_sent;
        while (jobs_sent < base + RAND_JOBS) begin
            r = $urandom_range(0, 9);
            case (r)
                0: begin
                    lanes = 7'd0;
                end
                1: begin
                    lanes = 7'd1;
                end
                2: begin
                    lanes = 7'd2;
                end
                3: begin
                    lanes = 7'd64;
                end
                4: begin
                    lanes = LANE_W'($urandom_range(65, 127));
                end
                default: begin
                    lanes = LANE_W'($urandom_range(1, 64));
                end
            endcase
            set_lane_count(lanes);
            burst = $urandom_range(20, 120);
            for (int k = 0; k < burst; k++) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    svc = SVC_W'($urandom_range(1, 65535));
                end else if (r < 85) begin
                    svc = SVC_W'($urandom_range(1, 8));
                end else if (r < 92) begin
                    svc = '0;
                end else if (r < 97) begin
                    svc = '1;
                end else begin
                    svc = SVC_W'($urandom);
                end
                send_job(svc, (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0),
                         1'b0, '0);
            end
        end

        job_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0 && pending_picks.size() == 0) begin
            $display("earliest_free_lane_assigner_top_tb: done, clean");
        end else begin
            $display("earliest_free_lane_assigner_top_tb: done, errors");
        end
        $finish;
    end

endmodule
